/* hdl/cpi_pkg.sv */
package cpi_pkg;

  // configuration register port
  localparam int CFG_W       = 12;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_LENGTH = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_CP_LENGTH     = CFG_INDEX_W'(1);

  localparam logic [CFG_W-1:0] SYMBOL_LENGTH_RESET = CFG_W'(64);
  localparam logic [CFG_W-1:0] CP_LENGTH_RESET     = CFG_W'(16);

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // flags that travel with one result
  typedef struct packed {
    logic is_prefix;
    logic end_of_symbol;
  } res_meta_t;

  // one or two results caused by a single input beat
  typedef struct packed {
    logic      two;
    res_meta_t m0;
    res_meta_t m1;
  } bundle_meta_t;

endpackage

/* hdl/cyclic_prefix_inserter_core.sv */
// OFDM cyclic prefix inserter
// in channel: one complex sample (in_i, in_q) per beat, symbol_length samples
// to a symbol. out channel: the previous symbol with its last cp_length
// samples copied in front, flagged by is_prefix, end_of_symbol on its final
// sample, last_of_run on the last result caused by one input beat.
// cfg channel: index 0 symbol_length, index 1 cp_length; any write to these
// restarts framing, so the next full symbol gives no output. cfg_ready is
// always high; write only while the block is idle.
// the results of an input beat pass the read stage, the queue and the output
// register. throughput: one output beat per cycle while out_ready is high, set
// by the output stage; an input in the prefix part of a symbol gives two
// results, otherwise one, so a symbol gives symbol_length + cp_length beats.
// reset: framing restarts, registers return to 64 and 16, the store is not
// cleared (its contents only reach the output after a full symbol is written).
// when out_ready is low the output beat holds and the queue between the
// store and the output fills; in_ready drops once it has no room left.
module cyclic_prefix_inserter_core
  import cpi_pkg::*;
#(
  parameter int MAX_SYMBOL_LENGTH = 2048,
  parameter int SAMPLE_WIDTH      = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_q,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_q,
  output logic                           is_prefix,
  output logic                           end_of_symbol,
  output logic                           last_of_run,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);

  localparam int DW = 4 * SAMPLE_WIDTH;
  localparam int QW = $bits(bundle_meta_t) + DW;

  logic                             push;
  bundle_meta_t                     push_meta;
  logic [DW-1:0]                    push_data;
  logic                             pop;
  logic                             head_valid;
  logic [QW-1:0]                    head_word;
  bundle_meta_t                     head_meta;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] fifo_count;

  cpi_front #(
    .MAX_SYMBOL_LENGTH (MAX_SYMBOL_LENGTH),
    .SAMPLE_WIDTH      (SAMPLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_i       (in_i),
    .in_q       (in_q),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fifo_count (fifo_count),
    .push       (push),
    .push_meta  (push_meta),
    .push_data  (push_data)
  );

  cpi_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (QW)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_meta, push_data}),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_word),
    .count      (fifo_count)
  );

  assign head_meta = head_word[QW-1:DW];

  cpi_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_meta     (head_meta),
    .head_data     (head_word[DW-1:0]),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_i         (out_i),
    .out_q         (out_q),
    .is_prefix     (is_prefix),
    .end_of_symbol (end_of_symbol),
    .last_of_run   (last_of_run)
  );

endmodule

/* hdl/cpi_fifo.sv */
module cpi_fifo
  import cpi_pkg::*;
#(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic                       head_valid,
  output logic [WIDTH-1:0]           head_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  // pointer wrap
  function automatic logic [PW-1:0] bump(input logic [PW-1:0] ptr);
    logic [PW-1:0] r;
    r = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
    return r;
  endfunction

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < CW'(DEPTH))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !push && !pop |=> $stable(count))
    else $error("queue count moved without a push or pop");
`endif

endmodule

/* hdl/cpi_front.sv */
module cpi_front
  import cpi_pkg::*;
#(
  parameter int MAX_SYMBOL_LENGTH = 2048,
  parameter int SAMPLE_WIDTH      = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_q,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_INDEX_W-1:0]               cfg_index,
  input  logic [CFG_W-1:0]                     cfg_data,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     fifo_count,
  output logic                                 push,
  output bundle_meta_t                         push_meta,
  output logic [4*SAMPLE_WIDTH-1:0]            push_data
);

  localparam int AW  = $clog2(MAX_SYMBOL_LENGTH);
  localparam int NW0 = $clog2(MAX_SYMBOL_LENGTH + 1);
  localparam int NW  = (NW0 > CFG_W) ? NW0 : CFG_W;
  localparam int KW  = NW + 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int DW  = 2 * SAMPLE_WIDTH;

  // length clamp: zero acts as one, saturate at the store size
  function automatic logic [NW-1:0] clamp_len(input logic [CFG_W-1:0] raw);
    logic [NW-1:0] v;
    v = NW'(raw);
    if (v == '0) begin
      v = NW'(1);
    end
    if (v > NW'(MAX_SYMBOL_LENGTH)) begin
      v = NW'(MAX_SYMBOL_LENGTH);
    end
    return v;
  endfunction

  function automatic logic [NW-1:0] min_len(input logic [CFG_W-1:0] c,
                                            input logic [NW-1:0] n);
    logic [NW-1:0] r;
    r = (NW'(c) > n) ? n : NW'(c);
    return r;
  endfunction

  localparam logic [NW-1:0] N_RESET = clamp_len(SYMBOL_LENGTH_RESET);
  localparam logic [NW-1:0] C_RESET = min_len(CP_LENGTH_RESET, N_RESET);

  logic [CFG_W-1:0] cp_raw;
  logic [NW-1:0]    n_eff;
  logic [NW-1:0]    c_eff;
  logic [NW-1:0]    n_minus_c;
  logic [KW-1:0]    k_end;
  logic [NW-1:0]    n_eff_next;
  logic [NW-1:0]    c_eff_next;
  logic             cfg_hit;

  logic [AW-1:0]    wpos;
  logic             bank;
  logic             prev_ready;

  logic             accept;
  logic [KW-1:0]    p_ext;
  logic             p_in_prefix;
  logic [KW-1:0]    k0;
  logic [KW-1:0]    k1;
  logic [KW-1:0]    src0;
  logic [KW-1:0]    src1;
  res_meta_t        m0;
  res_meta_t        m1;

  logic [DW-1:0]    store [2*MAX_SYMBOL_LENGTH];
  logic [DW-1:0]    rd0;
  logic [DW-1:0]    rd1;
  logic             s1_valid;
  bundle_meta_t     s1_meta;

  // configuration registers, written at any time
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_SYMBOL_LENGTH ||
                                   cfg_index == REG_CP_LENGTH);

  always_comb begin
    n_eff_next = n_eff;
    c_eff_next = c_eff;
    unique case (cfg_index)
      REG_SYMBOL_LENGTH: begin
        n_eff_next = clamp_len(cfg_data);
        c_eff_next = min_len(cp_raw, clamp_len(cfg_data));
      end
      REG_CP_LENGTH: begin
        c_eff_next = min_len(cfg_data, n_eff);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cp_raw    <= CP_LENGTH_RESET;
      n_eff     <= N_RESET;
      c_eff     <= C_RESET;
      n_minus_c <= N_RESET - C_RESET;
      k_end     <= KW'(N_RESET) + KW'(C_RESET) - KW'(1);
    end else if (cfg_hit) begin
      if (cfg_index == REG_CP_LENGTH) begin
        cp_raw <= cfg_data;
      end
      n_eff     <= n_eff_next;
      c_eff     <= c_eff_next;
      n_minus_c <= n_eff_next - c_eff_next;
      k_end     <= KW'(n_eff_next) + KW'(c_eff_next) - KW'(1);
    end
  end

  // room is reserved for the beat in the read stage as well
  assign in_ready = (CW'(fifo_count) + CW'(s1_valid)) < CW'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  // output positions caused by this input
  assign p_ext       = KW'(wpos);
  assign p_in_prefix = p_ext < KW'(c_eff);
  assign k0          = p_in_prefix ? {p_ext[KW-2:0], 1'b0} : p_ext + KW'(c_eff);
  assign k1          = {k0[KW-1:1], 1'b1};

  always_comb begin
    m0.is_prefix     = k0 < KW'(c_eff);
    m1.is_prefix     = k1 < KW'(c_eff);
    m0.end_of_symbol = (k0 == k_end);
    m1.end_of_symbol = (k1 == k_end);
    src0 = m0.is_prefix ? KW'(n_minus_c) + k0 : k0 - KW'(c_eff);
    src1 = m1.is_prefix ? KW'(n_minus_c) + k1 : k1 - KW'(c_eff);
  end

  // ping-pong store: write this bank, read the other
  always_ff @(posedge clk) begin
    if (accept) begin
      store[{bank, wpos}] <= {in_i, in_q};
      rd0 <= store[{~bank, src0[AW-1:0]}];
      rd1 <= store[{~bank, src1[AW-1:0]}];
    end
  end

  // framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      wpos       <= '0;
      bank       <= 1'b0;
      prev_ready <= 1'b0;
    end else if (cfg_hit) begin
      wpos       <= '0;
      prev_ready <= 1'b0;
    end else if (accept) begin
      if (p_ext + KW'(1) >= KW'(n_eff)) begin
        wpos       <= '0;
        bank       <= ~bank;
        prev_ready <= 1'b1;
      end else begin
        wpos <= wpos + AW'(1);
      end
    end
  end

  // read stage, always drained into the queue next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && prev_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta.two <= p_in_prefix;
      s1_meta.m0  <= m0;
      s1_meta.m1  <= m1;
    end
  end

  assign push      = s1_valid;
  assign push_meta = s1_meta;
  assign push_data = {rd0, rd1};

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    KW'(wpos) < KW'(n_eff))
    else $error("write position beyond symbol length");
  a_cp_clamped: assert property (@(posedge clk) disable iff (rst)
    c_eff <= n_eff && n_eff != '0)
    else $error("prefix length not clamped");
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> fifo_count < CW'(QUEUE_DEPTH))
    else $error("read stage pushed into a full queue");
`endif

endmodule

/* hdl/cpi_back.sv */
module cpi_back
  import cpi_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  bundle_meta_t                   head_meta,
  input  logic [4*SAMPLE_WIDTH-1:0]      head_data,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_q,
  output logic                           is_prefix,
  output logic                           end_of_symbol,
  output logic                           last_of_run
);

  localparam int SW = SAMPLE_WIDTH;

  logic      half;
  logic      load;
  logic      final_beat;
  res_meta_t sel_meta;
  logic [SW-1:0] sel_i;
  logic [SW-1:0] sel_q;

  // output register takes a beat when empty or drained
  assign load       = head_valid && (!out_valid || out_ready);
  assign final_beat = !head_meta.two || half;
  assign pop        = load && final_beat;

  always_comb begin
    if (half) begin
      sel_meta = head_meta.m1;
      sel_i    = head_data[2*SW-1:SW];
      sel_q    = head_data[SW-1:0];
    end else begin
      sel_meta = head_meta.m0;
      sel_i    = head_data[4*SW-1:3*SW];
      sel_q    = head_data[3*SW-1:2*SW];
    end
  end

  // beat sequencing over a bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        half      <= !final_beat;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_i         <= sel_i;
      out_q         <= sel_q;
      is_prefix     <= sel_meta.is_prefix;
      end_of_symbol <= sel_meta.end_of_symbol;
      last_of_run   <= final_beat;
    end
  end

`ifndef SYNTHESIS
  a_half_holds_head: assert property (@(posedge clk) disable iff (rst)
    half |-> head_valid && head_meta.two)
    else $error("second result pending without a two-result bundle");
  a_first_then_second: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> half)
    else $error("first of two results shown without second pending");
  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid && last_of_run)
    else $error("bundle released before its last result");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench
  import cpi_pkg::*;
();

  localparam int MAX_N          = 2048;
  localparam int SAMPLE_W       = 16;
  localparam int SETTLE_CYCLES  = 10;
  localparam int TIMEOUT_NS     = 2_000_000;
  localparam int RANDOM_SAMPLES = 400;
  localparam int MAX_PRINTED    = 30;

  // indexes outside the register list, writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = CFG_INDEX_W'(3);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t i;
    sample_t q;
  } iq_t;

  typedef struct packed {
    sample_t i;
    sample_t q;
    logic    is_prefix;
    logic    end_of_symbol;
    logic    last_of_run;
  } cp_beat_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  sample_t                in_i;
  sample_t                in_q;
  logic                   out_valid;
  logic                   out_ready;
  sample_t                out_i;
  sample_t                out_q;
  logic                   is_prefix;
  logic                   end_of_symbol;
  logic                   last_of_run;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  // stall limits, changed per test phase
  int in_gap_max    = 0;
  int out_stall_max = 0;

  int error_count = 0;
  int out_beats   = 0;

  // predictor state: ping-pong symbol store and framing
  iq_t        ofdm_store [0:2*MAX_N-1];
  logic [10:0] fill_pos;
  logic        fill_bank;
  logic        held_symbol_ok;
  logic [CFG_W-1:0] n_reg;
  logic [CFG_W-1:0] c_reg;

  cp_beat_t cp_beats_due [$];

  cyclic_prefix_inserter_core #(
    .MAX_SYMBOL_LENGTH(MAX_N),
    .SAMPLE_WIDTH     (SAMPLE_W)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_i         (in_i),
    .in_q         (in_q),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_i        (out_i),
    .out_q        (out_q),
    .is_prefix    (is_prefix),
    .end_of_symbol(end_of_symbol),
    .last_of_run  (last_of_run),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("mismatch: %s", msg);
  endtask

  // queue position k of the held symbol for the output side
  function automatic void queue_prefixed_beat(input int k, input int n, input int c,
                                              input bit last);
    cp_beat_t beat;
    int src;
    src = (k < c) ? (n - c + k) : (k - c);
    beat.i = ofdm_store[(fill_bank ? 0 : MAX_N) + src].i;
    beat.q = ofdm_store[(fill_bank ? 0 : MAX_N) + src].q;
    beat.is_prefix     = (k < c);
    beat.end_of_symbol = (k == n + c - 1);
    beat.last_of_run   = last;
    cp_beats_due.push_back(beat);
  endfunction

  // one accepted input sample: emit from the held symbol, then store it
  function automatic void insert_prefix_for(input iq_t s);
    int n;
    int c;
    int p;
    n = (n_reg == 0) ? 1 : ((n_reg > MAX_N) ? MAX_N : int'(n_reg));
    c = (c_reg > n) ? n : int'(c_reg);
    p = fill_pos;
    if (p >= n) p = n - 1;
    if (held_symbol_ok) begin
      if (p < c) begin
        queue_prefixed_beat(2 * p, n, c, 1'b0);
        queue_prefixed_beat(2 * p + 1, n, c, 1'b1);
      end else begin
        queue_prefixed_beat(p + c, n, c, 1'b1);
      end
    end
    ofdm_store[(fill_bank ? MAX_N : 0) + p] = s;
    if (p + 1 >= n) begin
      fill_pos       = '0;
      fill_bank      = ~fill_bank;
      held_symbol_ok = 1'b1;
    end else begin
      fill_pos = 11'(p + 1);
    end
  endfunction

  // any listed register restarts framing, the bank is kept
  function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
    case (idx)
      REG_SYMBOL_LENGTH: n_reg = val;
      REG_CP_LENGTH:     c_reg = val;
      default:           return;
    endcase
    fill_pos       = '0;
    held_symbol_ok = 1'b0;
  endfunction

  function automatic logic [SAMPLE_W-1:0] extreme_value(input int k);
    case (k % 7)
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      5:       return 16'h5555;
      default: return 16'hAAAA;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_value();
    if ($urandom_range(0, 7) == 0) return extreme_value($urandom_range(0, 6));
    return SAMPLE_W'($urandom);
  endfunction

  // one input beat; valid stays high after acceptance until the next call
  // changes or lowers it, or wait_idle lowers it, at the following falling edge
  task automatic send_sample(input logic [SAMPLE_W-1:0] si, input logic [SAMPLE_W-1:0] sq);
    int gap;
    iq_t s;
    gap = $urandom_range(0, in_gap_max);
    s.i = si;
    s.q = sq;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_i     <= si;
    in_q     <= sq;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    insert_prefix_for(s);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(random_value(), random_value());
  endtask

  task automatic send_extremes(input int count, input int first);
    for (int k = first; k < first + count; k++) send_sample(extreme_value(k), extreme_value(k + 3));
  endtask

  // stop input, drain all expected beats, then let samples without output settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cp_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    apply_reg_write(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // register values after reset, 64 samples with a 16 sample prefix
  task automatic test_reset_values();
    in_gap_max    = 3;
    out_stall_max = 3;
    send_random(3 * 64);
  endtask

  // zero length acts as one sample per symbol, with and without prefix
  task automatic test_single_sample_symbols();
    in_gap_max    = 1;
    out_stall_max = 2;
    write_reg(REG_SYMBOL_LENGTH, '0);
    write_reg(REG_CP_LENGTH, '0);
    send_extremes(4, 0);
    write_reg(REG_CP_LENGTH, CFG_W'(1));
    send_extremes(4, 4);
  endtask

  // prefix longer than the symbol is clamped; spare index writes do nothing
  task automatic test_prefix_clamp();
    write_reg(REG_SYMBOL_LENGTH, CFG_W'(3));
    write_reg(REG_CP_LENGTH, '1);
    send_extremes(4, 1);
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, '0);
    send_extremes(5, 5);
  endtask

  // no prefix, and a half symbol left behind for the next write to drop
  task automatic test_partial_symbol_drop();
    in_gap_max    = 0;
    out_stall_max = 0;
    write_reg(REG_SYMBOL_LENGTH, CFG_W'(4));
    write_reg(REG_CP_LENGTH, '0);
    send_extremes(6, 2);
  endtask

  // oversized length saturates, so a short run stays inside the first symbol
  // and gives no output; the reset length is restored afterwards
  task automatic test_longest_symbol();
    in_gap_max    = 0;
    out_stall_max = 3;
    write_reg(REG_SYMBOL_LENGTH, '1);
    write_reg(REG_CP_LENGTH, '1);
    send_random(64);
    write_reg(REG_SYMBOL_LENGTH, SYMBOL_LENGTH_RESET);
  endtask

  // random small settings, whole symbols plus an optional partial one
  task automatic test_random_phases();
    int sent;
    int n_eff;
    int n_val;
    int c_val;
    int mode;
    int count;
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      in_gap_max    = 3 * $urandom_range(0, 1);
      out_stall_max = 3 * $urandom_range(0, 1);
      case ($urandom_range(0, 9))
        0:       n_val = 0;
        1:       n_val = $urandom_range(20, 80);
        default: n_val = $urandom_range(1, 16);
      endcase
      n_eff = (n_val == 0) ? 1 : n_val;
      case ($urandom_range(0, 5))
        0:       c_val = 0;
        1:       c_val = n_eff + $urandom_range(1, 40);
        2:       c_val = n_eff;
        default: c_val = $urandom_range(0, n_eff);
      endcase
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE_2, CFG_W'($urandom));
      mode = $urandom_range(0, 3);
      if (mode == 0) begin
        write_reg(REG_SYMBOL_LENGTH, CFG_W'(n_val));
      end else if (mode == 1) begin
        write_reg(REG_CP_LENGTH, CFG_W'(c_val));
      end else if (mode == 2) begin
        write_reg(REG_SYMBOL_LENGTH, CFG_W'(n_val));
        write_reg(REG_CP_LENGTH, CFG_W'(c_val));
      end else begin
        write_reg(REG_CP_LENGTH, CFG_W'(c_val));
        write_reg(REG_SYMBOL_LENGTH, CFG_W'(n_val));
      end
      // length actually in force may come from an earlier phase
      n_eff = (n_reg == 0) ? 1 : ((n_reg > MAX_N) ? MAX_N : int'(n_reg));
      count = $urandom_range(2, 4) * n_eff;
      if ($urandom_range(0, 2) == 0) count += $urandom_range(0, n_eff - 1);
      send_random(count);
      sent += count;
    end
  endtask

  // output side stall pattern
  initial begin : output_stall
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = $urandom_range(0, out_stall_max);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  // compare every output beat with the oldest expected one
  always @(posedge clk) begin : check_output
    cp_beat_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (cp_beats_due.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with nothing expected", out_beats));
      end else begin
        want = cp_beats_due.pop_front();
        if (out_i !== want.i)
          report_mismatch($sformatf("beat %0d out_i %h, want %h", out_beats, out_i, want.i));
        if (out_q !== want.q)
          report_mismatch($sformatf("beat %0d out_q %h, want %h", out_beats, out_q, want.q));
        if (is_prefix !== want.is_prefix)
          report_mismatch($sformatf("beat %0d is_prefix %b, want %b", out_beats, is_prefix,
                                    want.is_prefix));
        if (end_of_symbol !== want.end_of_symbol)
          report_mismatch($sformatf("beat %0d end_of_symbol %b, want %b", out_beats,
                                    end_of_symbol, want.end_of_symbol));
        if (last_of_run !== want.last_of_run)
          report_mismatch($sformatf("beat %0d last_of_run %b, want %b", out_beats, last_of_run,
                                    want.last_of_run));
      end
      out_beats++;
    end
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_i           = '0;
    in_q           = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_SYMBOL_LENGTH;
    cfg_data       = '0;
    n_reg          = SYMBOL_LENGTH_RESET;
    c_reg          = CP_LENGTH_RESET;
    fill_pos       = '0;
    fill_bank      = 1'b0;
    held_symbol_ok = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_single_sample_symbols();
    test_prefix_clamp();
    test_partial_symbol_drop();
    test_longest_symbol();
    test_random_phases();

    wait_idle();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/cpi_pkg.sv
hdl/cpi_fifo.sv
hdl/cpi_front.sv
hdl/cpi_back.sv
hdl/cyclic_prefix_inserter_core.sv
bench/testbench.sv
